/* rtl/core/hashed_force_accumulator_unit_defines.svh */
// Assertion macros used by the hashed force accumulator RTL.
`ifndef HASHED_FORCE_ACCUMULATOR_UNIT_DEFINES_SVH
`define HASHED_FORCE_ACCUMULATOR_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define HFA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("hashed force accumulator: same-cycle check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define HFA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("hashed force accumulator: next-cycle check failed");

`endif

/* rtl/core/hfa_pkg.sv */
// Types, codes and arithmetic helpers of the hashed force accumulator.
`timescale 1ns / 1ps

package hfa_pkg;

    localparam logic [1:0] ACT_CLEAR  = 2'd0;
    localparam logic [1:0] ACT_ACCUM  = 2'd1;
    localparam logic [1:0] ACT_LOOKUP = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO_KEY = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    // Fibonacci hashing multiplier.
    localparam logic [63:0] FIB_MULT = 64'h9E3779B97F4A7C15;

    typedef struct packed {
        logic [1:0]         action;
        logic [31:0]        entity;
        logic signed [31:0] in_fx;
        logic signed [31:0] in_fy;
        logic signed [31:0] in_fz;
        logic signed [31:0] in_tx;
        logic signed [31:0] in_ty;
        logic signed [31:0] in_tz;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic               found;
        logic signed [31:0] out_fx;
        logic signed [31:0] out_fy;
        logic signed [31:0] out_fz;
        logic signed [31:0] out_tx;
        logic signed [31:0] out_ty;
        logic signed [31:0] out_tz;
    } t_out_item;

    // One table slot as held in memory.
    typedef struct packed {
        logic               valid;
        logic [31:0]        key;
        logic signed [31:0] fx;
        logic signed [31:0] fy;
        logic signed [31:0] fz;
        logic signed [31:0] tx;
        logic signed [31:0] ty;
        logic signed [31:0] tz;
    } t_entry;

    // Saturating Q16.16 addition.
    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [32:0] s;
        s = {a[31], a} + {b[31], b};
        if (s[32] != s[31]) begin
            return s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        return s[31:0];
    endfunction

endpackage

/* rtl/core/hashed_force_accumulator_unit.sv */
// Top level of the hashed force accumulator: a linear-probing table in one memory.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+-------------------------
//  in      | to block  | i_in_valid / o_in_stall  | i_in_item  (t_in_item)
//  out     | from block| o_out_valid / i_out_stall| o_out_item (t_out_item)
//
// Accumulate and lookup probe one slot per cycle through the single read port of
// the table memory; a hashing step comes first.
// Zero-key items and the unused action code go straight to the response; a clear
// item sweeps every slot invalid, one a cycle.
// After reset the same sweep runs with the input stalled.
// A result waits in the output register while the next item is accepted; only a
// second result held back by i_out_stall stalls the block.
`timescale 1ns / 1ps
`include "hashed_force_accumulator_unit_defines.svh"

module hashed_force_accumulator_unit #(
    parameter int TABLE_SLOTS = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  hfa_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output hfa_pkg::t_out_item  o_out_item
);

    localparam int SLOT_W = $clog2(TABLE_SLOTS);
    localparam logic [31:0]       C_LO = hfa_pkg::FIB_MULT[31:0];
    localparam logic [SLOT_W-1:0] C_HI = hfa_pkg::FIB_MULT[32 +: SLOT_W];

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_HASH  = 6'b000100,
        S_PROBE = 6'b001000,
        S_WRITE = 6'b010000,
        S_RESP  = 6'b100000
    } t_state;

    t_state                 r_state;
    t_state                 n_state;
    logic [SLOT_W-1:0]      r_clr_addr;
    logic                   r_clr_resp;
    logic [SLOT_W-1:0]      r_slot;
    logic [SLOT_W-1:0]      r_count;
    logic                   r_out_valid;

    hfa_pkg::t_in_item      r_item;
    hfa_pkg::t_out_item     r_resp;
    hfa_pkg::t_out_item     n_resp;
    hfa_pkg::t_out_item     r_out;
    hfa_pkg::t_entry        r_entry;
    logic [SLOT_W-1:0]      r_hash_lo;
    logic [SLOT_W-1:0]      r_hash_hi;

    hfa_pkg::t_entry        r_mem [TABLE_SLOTS];
    hfa_pkg::t_entry        r_rd_data;

    logic                   in_accept;
    logic                   out_free;
    logic [63:0]            prod_lo;
    logic [SLOT_W-1:0]      prod_hi;
    logic [SLOT_W-1:0]      hash_slot;
    logic                   rd_en;
    logic [SLOT_W-1:0]      rd_addr;
    logic                   wr_en;
    logic [SLOT_W-1:0]      wr_addr;
    hfa_pkg::t_entry        wr_data;
    logic                   probe_hit;
    logic                   probe_last;
    logic                   is_accum;
    logic                   keyed_action;

    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // The home slot needs only product bits 32 and up, so the 64-bit constant splits
    // into a 32x32 product for the carry part and a narrow one for the upper part.
    assign prod_lo   = 64'(i_in_item.entity) * 64'(C_LO);
    assign prod_hi   = i_in_item.entity[SLOT_W-1:0] * C_HI;
    assign hash_slot = r_hash_lo + r_hash_hi;

    assign is_accum     = (r_item.action == hfa_pkg::ACT_ACCUM);
    assign keyed_action = (i_in_item.action == hfa_pkg::ACT_ACCUM) ||
                          (i_in_item.action == hfa_pkg::ACT_LOOKUP);
    assign probe_hit    = !r_rd_data.valid || (r_rd_data.key == r_item.entity);
    assign probe_last   = (r_count == SLOT_W'(TABLE_SLOTS - 1));

    assign rd_en   = (r_state == S_HASH) || (r_state == S_PROBE);
    assign rd_addr = (r_state == S_HASH) ? hash_slot : r_slot + 1'b1;
    assign wr_en   = (r_state == S_WRITE) || (r_state == S_CLEAR);
    assign wr_addr = (r_state == S_CLEAR) ? r_clr_addr : r_slot;

    always_comb begin
        wr_data = '0;
        if (r_state == S_WRITE) begin
            wr_data.valid = 1'b1;
            wr_data.key   = r_item.entity;
            if (r_entry.valid) begin
                wr_data.fx = hfa_pkg::sat_add(r_entry.fx, r_item.in_fx);
                wr_data.fy = hfa_pkg::sat_add(r_entry.fy, r_item.in_fy);
                wr_data.fz = hfa_pkg::sat_add(r_entry.fz, r_item.in_fz);
                wr_data.tx = hfa_pkg::sat_add(r_entry.tx, r_item.in_tx);
                wr_data.ty = hfa_pkg::sat_add(r_entry.ty, r_item.in_ty);
                wr_data.tz = hfa_pkg::sat_add(r_entry.tz, r_item.in_tz);
            end else begin
                wr_data.fx = r_item.in_fx;
                wr_data.fy = r_item.in_fy;
                wr_data.fz = r_item.in_fz;
                wr_data.tx = r_item.in_tx;
                wr_data.ty = r_item.in_ty;
                wr_data.tz = r_item.in_tz;
            end
        end
    end

    // Table memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == SLOT_W'(TABLE_SLOTS - 1)) begin
                    n_state = r_clr_resp ? S_RESP : S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_accept) begin
                    case (i_in_item.action) inside
                        hfa_pkg::ACT_CLEAR: n_state = S_CLEAR;
                        hfa_pkg::ACT_ACCUM, hfa_pkg::ACT_LOOKUP: begin
                            n_state = (i_in_item.entity == '0) ? S_RESP : S_HASH;
                        end
                        default: n_state = S_RESP;
                    endcase
                end
            end
            S_HASH: n_state = S_PROBE;
            S_PROBE: begin
                if (probe_hit) begin
                    n_state = is_accum ? S_WRITE : S_RESP;
                end else if (probe_last) begin
                    n_state = S_RESP;
                end
            end
            S_WRITE: n_state = S_RESP;
            S_RESP: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // The result is built up while the item is worked on and copied out in S_RESP.
    always_comb begin
        n_resp = r_resp;
        if (in_accept) begin
            n_resp = '0;
            if (keyed_action && i_in_item.entity == '0) begin
                n_resp.status = hfa_pkg::ST_ZERO_KEY;
            end else begin
                n_resp.status = hfa_pkg::ST_OK;
            end
        end else if (r_state == S_PROBE) begin
            if (probe_hit && !is_accum && r_rd_data.valid) begin
                n_resp.found  = 1'b1;
                n_resp.out_fx = r_rd_data.fx;
                n_resp.out_fy = r_rd_data.fy;
                n_resp.out_fz = r_rd_data.fz;
                n_resp.out_tx = r_rd_data.tx;
                n_resp.out_ty = r_rd_data.ty;
                n_resp.out_tz = r_rd_data.tz;
            end else if (!probe_hit && probe_last && is_accum) begin
                n_resp.status = hfa_pkg::ST_FULL;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_clr_resp  <= 1'b0;
            r_slot      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (in_accept) begin
                r_clr_addr <= '0;
                r_clr_resp <= (i_in_item.action == hfa_pkg::ACT_CLEAR);
            end
            if (r_state == S_HASH) begin
                r_slot  <= hash_slot;
                r_count <= '0;
            end else if (r_state == S_PROBE && !probe_hit) begin
                r_slot  <= r_slot + 1'b1;
                r_count <= r_count + 1'b1;
            end
            if (r_state == S_RESP && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_resp <= n_resp;
        if (in_accept) begin
            r_item    <= i_in_item;
            r_hash_lo <= prod_lo[32 +: SLOT_W];
            r_hash_hi <= prod_hi;
        end
        if (r_state == S_PROBE) begin
            r_entry <= r_rd_data;
        end
        if (r_state == S_RESP && out_free) begin
            r_out <= r_resp;
        end
    end

    `HFA_ASSERT_NEXT(a_accept_leaves_idle, in_accept, r_state != S_IDLE)
    `HFA_ASSERT_NOW(a_no_zero_key_probe, r_state == S_PROBE, r_item.entity != '0)
    `HFA_ASSERT_NOW(a_write_only_accum, r_state == S_WRITE, r_item.action == hfa_pkg::ACT_ACCUM)
    `HFA_ASSERT_NOW(a_found_is_ok, o_out_valid && o_out_item.found, o_out_item.status == hfa_pkg::ST_OK)

endmodule
